// File: design/dcp_pkg.sv
// Shared types and constants for the distance constraint projection unit.
`default_nettype none
package dcp_pkg;

    localparam int D_W   = 35;
    localparam int S_W   = 67;
    localparam int N_W   = 100;
    localparam int DEN_W = 68;
    localparam int Q_W   = 32;

    localparam logic [1:0] KIND_EQUAL    = 2'd0;
    localparam logic [1:0] KIND_AT_LEAST = 2'd1;
    localparam logic [1:0] KIND_AT_MOST  = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [1:0] OUT_MOVED      = 2'd0;
    localparam logic [1:0] OUT_SATISFIED  = 2'd1;
    localparam logic [1:0] OUT_AT_LENGTH  = 2'd2;
    localparam logic [1:0] OUT_COINCIDENT = 2'd3;

    typedef struct packed {
        logic [15:0]        first_index;
        logic [15:0]        second_index;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic [31:0]        first_mass;
        logic [31:0]        second_mass;
        logic [30:0]        rest_length;
        logic [1:0]         kind;
    } t_req;

    typedef struct packed {
        logic [15:0]        out_first_index;
        logic [15:0]        out_second_index;
        logic signed [31:0] move_first_x;
        logic signed [31:0] move_first_y;
        logic signed [31:0] move_first_z;
        logic signed [31:0] move_second_x;
        logic signed [31:0] move_second_y;
        logic signed [31:0] move_second_z;
        logic [1:0]         outcome;
    } t_rsp;

endpackage
`default_nettype wire

// File: design/distance_constraint_projection_unit.sv
// Top level: distance constraint projection pipeline.
// Throughput: one request per cycle while not stalled (o_valid low or i_ready
// high); the whole pipeline advances together.
// Stages: difference, squares, sum, 35 root-bit stages, error, three multiply
// stages, 33 divider stages (overflow check plus one quotient bit each), output.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module distance_constraint_projection_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire dcp_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output dcp_pkg::t_rsp      o_rsp
);
    localparam int DW  = dcp_pkg::D_W;
    localparam int SQ  = dcp_pkg::D_W;
    localparam int DV  = dcp_pkg::Q_W + 1;

    typedef struct packed {
        logic          v;
        dcp_pkg::t_req p;
        logic [2:0][32:0] df;
    } t_sq_pl;

    typedef struct packed {
        logic        v;
        logic [15:0] i1;
        logic [15:0] i2;
        logic [1:0]  oc;
        logic [2:0]  sn;
    } t_dv_pl;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    t_sq_pl           r1, r2, r3;
    logic [2:0][65:0] r2_sq;
    logic [66:0]      r3_s;
    t_sq_pl           r_sp [SQ];
    logic [DW-1:0]    root;

    logic [2:0][32:0] n_df;
    assign n_df[0] = {i_req.first_x[31], i_req.first_x} - {i_req.second_x[31], i_req.second_x};
    assign n_df[1] = {i_req.first_y[31], i_req.first_y} - {i_req.second_y[31], i_req.second_y};
    assign n_df[2] = {i_req.first_z[31], i_req.first_z} - {i_req.second_z[31], i_req.second_z};

    logic [2:0][32:0] ab1;
    for (genvar i = 0; i < 3; i++) begin : g_ab1
        assign ab1[i] = r1.df[i][32] ? 33'(-r1.df[i]) : r1.df[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1.v <= 1'b0;
            r2.v <= 1'b0;
            r3.v <= 1'b0;
        end else if (en) begin
            r1.v <= i_valid;
            r2.v <= r1.v;
            r3.v <= r2.v;
        end
        if (en) begin
            r1.p  <= i_req;
            r1.df <= n_df;
            r2.p  <= r1.p;
            r2.df <= r1.df;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= {33'b0, ab1[i]} * {33'b0, ab1[i]};
            end
            r3.p  <= r2.p;
            r3.df <= r2.df;
            r3_s  <= {1'b0, r2_sq[0]} + {1'b0, r2_sq[1]} + {1'b0, r2_sq[2]};
        end
    end

    dcp_sqrt_pipe u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (r3_s),
        .o_root (root)
    );

    for (genvar k = 0; k < SQ; k++) begin : g_sp
        t_sq_pl src;
        if (k == 0) begin : g_head
            assign src = r3;
        end else begin : g_tail
            assign src = r_sp[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sp[k].v <= 1'b0;
            end else if (en) begin
                r_sp[k].v <= src.v;
            end
            if (en) begin
                r_sp[k].p  <= src.p;
                r_sp[k].df <= src.df;
            end
        end
    end

    // error stage
    t_sq_pl        sp;
    logic [DW-1:0] len;
    logic          ineq, eneg;
    logic [1:0]    n_oc;
    logic [31:0]   m1, m2;
    assign sp   = r_sp[SQ-1];
    assign len  = {4'b0, sp.p.rest_length};
    assign ineq = (sp.p.kind == dcp_pkg::KIND_AT_LEAST && root >= len)
               || (sp.p.kind == dcp_pkg::KIND_AT_MOST && root <= len);
    assign eneg = root < len;
    assign m1   = (sp.p.first_mass == '0 && sp.p.second_mass == '0) ? 32'd1 : sp.p.first_mass;
    assign m2   = (sp.p.first_mass == '0 && sp.p.second_mass == '0) ? 32'd1 : sp.p.second_mass;

    always_comb begin
        if (ineq)             n_oc = dcp_pkg::OUT_SATISFIED;
        else if (root == len) n_oc = dcp_pkg::OUT_AT_LENGTH;
        else if (root == '0)  n_oc = dcp_pkg::OUT_COINCIDENT;
        else                  n_oc = dcp_pkg::OUT_MOVED;
    end

    logic             re_v, rm1_v, rm2_v, rm3_v;
    t_dv_pl           re_pl, rm1_pl, rm2_pl, rm3_pl;
    logic [DW-1:0]    re_eabs, re_d;
    logic [2:0][32:0] re_a;
    logic [31:0]      re_m1, re_m2, rm1_m1, rm1_m2;
    logic [32:0]      re_msum;
    logic [2:0][67:0] rm1_pe;
    logic [67:0]      rm1_den, rm2_den, rm3_den;
    logic [5:0][65:0] rm2_lo, rm2_hi;
    logic [5:0][99:0] rm3_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            re_v  <= 1'b0;
            rm1_v <= 1'b0;
            rm2_v <= 1'b0;
            rm3_v <= 1'b0;
        end else if (en) begin
            re_v  <= sp.v;
            rm1_v <= re_v;
            rm2_v <= rm1_v;
            rm3_v <= rm2_v;
        end
        if (en) begin
            re_pl.v  <= sp.v;
            re_pl.i1 <= sp.p.first_index;
            re_pl.i2 <= sp.p.second_index;
            re_pl.oc <= n_oc;
            re_eabs  <= eneg ? len - root : root - len;
            re_d     <= root;
            re_m1    <= m1;
            re_m2    <= m2;
            re_msum  <= {1'b0, m1} + {1'b0, m2};
            for (int i = 0; i < 3; i++) begin
                re_a[i]     <= sp.df[i][32] ? 33'(-sp.df[i]) : sp.df[i];
                re_pl.sn[i] <= sp.df[i][32] ^ eneg;
            end
            rm1_pl  <= re_pl;
            rm1_m1  <= re_m1;
            rm1_m2  <= re_m2;
            rm1_den <= {33'b0, re_d} * {35'b0, re_msum};
            for (int i = 0; i < 3; i++) begin
                rm1_pe[i] <= {35'b0, re_a[i]} * {33'b0, re_eabs};
            end
            rm2_pl  <= rm1_pl;
            rm2_den <= rm1_den;
            for (int j = 0; j < 6; j++) begin
                rm2_lo[j] <= {32'b0, rm1_pe[j % 3][33:0]}
                           * {34'b0, (j < 3) ? rm1_m2 : rm1_m1};
                rm2_hi[j] <= {32'b0, rm1_pe[j % 3][67:34]}
                           * {34'b0, (j < 3) ? rm1_m2 : rm1_m1};
            end
            rm3_pl  <= rm2_pl;
            rm3_den <= rm2_den;
            for (int j = 0; j < 6; j++) begin
                rm3_n[j] <= {34'b0, rm2_lo[j]} + {rm2_hi[j], 34'b0};
            end
        end
    end

    logic [5:0][31:0] quo;
    logic [5:0]       ovf;
    for (genvar j = 0; j < 6; j++) begin : g_div
        dcp_div_pipe u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (rm3_n[j]),
            .i_den (rm3_den),
            .o_quo (quo[j]),
            .o_ovf (ovf[j])
        );
    end

    t_dv_pl r_dp [DV];
    for (genvar k = 0; k < DV; k++) begin : g_dp
        t_dv_pl src;
        if (k == 0) begin : g_head
            assign src = {rm3_v, rm3_pl.i1, rm3_pl.i2, rm3_pl.oc, rm3_pl.sn};
        end else begin : g_tail
            assign src = r_dp[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dp[k].v <= 1'b0;
            end else if (en) begin
                r_dp[k].v <= src.v;
            end
            if (en) begin
                r_dp[k].i1 <= src.i1;
                r_dp[k].i2 <= src.i2;
                r_dp[k].oc <= src.oc;
                r_dp[k].sn <= src.sn;
            end
        end
    end

    // saturate and sign
    t_dv_pl           dp;
    logic [5:0][31:0] mv;
    assign dp = r_dp[DV-1];
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            if (dp.oc != dcp_pkg::OUT_MOVED) begin
                mv[j] = '0;
            end else if ((j < 3) ? !dp.sn[j % 3] : dp.sn[j % 3]) begin
                if (ovf[j] || quo[j] > 32'h8000_0000) mv[j] = 32'h8000_0000;
                else                                  mv[j] = 32'(-quo[j]);
            end else begin
                if (ovf[j] || quo[j] > 32'h7FFF_FFFF) mv[j] = 32'h7FFF_FFFF;
                else                                  mv[j] = quo[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dp.v;
        end
        if (en) begin
            o_rsp.out_first_index  <= dp.i1;
            o_rsp.out_second_index <= dp.i2;
            o_rsp.move_first_x     <= mv[0];
            o_rsp.move_first_y     <= mv[1];
            o_rsp.move_first_z     <= mv[2];
            o_rsp.move_second_x    <= mv[3];
            o_rsp.move_second_y    <= mv[4];
            o_rsp.move_second_z    <= mv[5];
            o_rsp.outcome          <= dp.oc;
        end
    end

    a_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.outcome != dcp_pkg::OUT_MOVED) |->
        (o_rsp.move_first_x == 0 && o_rsp.move_first_y == 0 && o_rsp.move_first_z == 0
         && o_rsp.move_second_x == 0 && o_rsp.move_second_y == 0
         && o_rsp.move_second_z == 0))
        else $error("move on non-moved outcome");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dp[DV-1].v) && $stable(r_sp[SQ-1].v))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// File: design/dcp_sqrt_pipe.sv
// Pipelined truncated square root, one result bit per stage.
`default_nettype none
module dcp_sqrt_pipe (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [dcp_pkg::S_W-1:0]   i_s,
    output logic      [dcp_pkg::D_W-1:0]   o_root
);
    localparam int DW = dcp_pkg::D_W;
    localparam int SW = dcp_pkg::S_W;

    logic [SW-1:0]   r_s  [DW];
    logic [DW-1:0]   r_r  [DW];
    logic [2*DW-1:0] r_r2 [DW];

    for (genvar k = 0; k < DW; k++) begin : g_st
        localparam int B = DW - 1 - k;
        logic [SW-1:0]   s_in;
        logic [DW-1:0]   r_in;
        logic [2*DW-1:0] r2_in;
        logic [2*DW-1:0] c2;
        if (k == 0) begin : g_first
            assign s_in  = i_s;
            assign r_in  = '0;
            assign r2_in = '0;
        end else begin : g_next
            assign s_in  = r_s[k-1];
            assign r_in  = r_r[k-1];
            assign r2_in = r_r2[k-1];
        end
        assign c2 = r2_in + ({{DW{1'b0}}, r_in} << (B + 1))
                  + ({{(2*DW-1){1'b0}}, 1'b1} << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k] <= s_in;
                if (c2 <= {{(2*DW-SW){1'b0}}, s_in}) begin
                    r_r[k]  <= r_in | ({{(DW-1){1'b0}}, 1'b1} << B);
                    r_r2[k] <= c2;
                end else begin
                    r_r[k]  <= r_in;
                    r_r2[k] <= r2_in;
                end
            end
        end
    end

    assign o_root = r_r[DW-1];
endmodule
`default_nettype wire

// File: design/dcp_div_pipe.sv
// Pipelined restoring divider: an overflow-check stage, then one quotient bit per stage.
`default_nettype none
module dcp_div_pipe (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [dcp_pkg::N_W-1:0]     i_num,
    input  wire logic [dcp_pkg::DEN_W-1:0]   i_den,
    output logic      [dcp_pkg::Q_W-1:0]     o_quo,
    output logic                             o_ovf
);
    localparam int NW = dcp_pkg::N_W;
    localparam int DW = dcp_pkg::DEN_W;
    localparam int QW = dcp_pkg::Q_W;
    localparam int ST = QW + 1;

    logic [NW-1:0] r_rem [ST];
    logic [DW-1:0] r_den [ST];
    logic [QW-1:0] r_q   [ST];
    logic          r_ovf [ST];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= i_num >= {i_den, {QW{1'b0}}};
        end
    end

    for (genvar k = 1; k < ST; k++) begin : g_st
        localparam int B = QW - k;
        logic [NW-1:0] t;
        assign t = {{(NW-DW){1'b0}}, r_den[k-1]} << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
                if (r_rem[k-1] >= t) begin
                    r_rem[k] <= r_rem[k-1] - t;
                    r_q[k]   <= r_q[k-1] | ({{(QW-1){1'b0}}, 1'b1} << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
            end
        end
    end

    assign o_quo = r_q[ST-1];
    assign o_ovf = r_ovf[ST-1];
endmodule
`default_nettype wire
